>>> hdl/scfw_pkg.sv
`default_nettype none
package scfw_pkg;

    localparam int NUM_TAPS_DEF     = 32;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 24;
    localparam int TABLE_LEN        = 32;
    localparam int COEF_INDEX_W     = 5;

    // item kinds carried on tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // startup weights, Q2.22
    localparam logic signed [23:0] INIT_W_Q22 [TABLE_LEN] = '{
        24'sd2208001, -24'sd418259, -24'sd122778, -24'sd43724,
        -24'sd182155, -24'sd77937, -24'sd34273, -24'sd54116,
        -24'sd35439, 24'sd58213, -24'sd50319, 24'sd30673,
        24'sd15796, -24'sd6653, 24'sd18225, 24'sd15644,
        24'sd6783, 24'sd8616, 24'sd11389, -24'sd1451,
        -24'sd11882, 24'sd223, -24'sd9220, 24'sd6923,
        24'sd11550, 24'sd1940, -24'sd1629, -24'sd3318,
        -24'sd4242, -24'sd4245, -24'sd10298, 24'sd1083
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN_A,
        S_DRAIN_B,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;     // latch a sample pair
        logic wr_coef;  // store one weight
        logic issue;    // one tap read this cycle
        logic first;    // tap zero
        logic finish;   // form the result and advance histories
    } t_cmd;

    typedef struct packed {
        logic out_busy; // result register full and not taken
    } t_stat;

    // startup weight of a tap, rescaled to cw bits and saturated
    function automatic logic signed [63:0] init_weight(input int idx, input int cw);
        logic signed [63:0] v;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        begin
            hi = (64'sd1 <<< (cw - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            if (idx >= TABLE_LEN) begin
                v = 64'sd0;
            end else begin
                v = 64'(INIT_W_Q22[idx]);
                if (cw >= 24) begin
                    v = v <<< (cw - 24);
                end else begin
                    v = (v + (64'sd1 <<< (23 - cw))) >>> (24 - cw);
                end
            end
            if (v > hi) begin
                v = hi;
            end else if (v < lo) begin
                v = lo;
            end
            return v;
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/scfw_ctrl.sv
`default_nettype none
module scfw_ctrl
    import scfw_pkg::*;
#(
    parameter int NUM_TAPS = NUM_TAPS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_op,
    output logic                              o_in_ready,
    input  wire t_stat                        i_stat,
    output t_cmd                              o_cmd,
    output logic [$clog2(NUM_TAPS)-1:0]       o_rd_addr
);

    localparam int AW = $clog2(NUM_TAPS);
    localparam logic [AW-1:0] LAST_TAP = AW'(NUM_TAPS - 1);

    t_state r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid && i_in_op == OP_SAMPLE) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (r_cnt == LAST_TAP) begin
                    n_state = S_DRAIN_A;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN_A: n_state = S_DRAIN_B;
            S_DRAIN_B: n_state = S_DONE;
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load     = i_in_valid && i_in_op == OP_SAMPLE;
                o_cmd.wr_coef  = i_in_valid && i_in_op == OP_COEF;
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = r_cnt == '0;
            end
            S_DONE: o_cmd.finish = !i_stat.out_busy;
            default: o_cmd = '0;
        endcase
    end

    assign o_rd_addr = r_cnt;

endmodule
`default_nettype wire

>>> hdl/scfw_dp.sv
`default_nettype none
module scfw_dp
    import scfw_pkg::*;
#(
    parameter int NUM_TAPS     = NUM_TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_cmd                            i_cmd,
    input  wire logic [$clog2(NUM_TAPS)-1:0]     i_rd_addr,
    output t_stat                                o_stat,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  i_left_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  i_right_sample,
    input  wire logic [COEF_INDEX_W-1:0]         i_coef_index,
    input  wire logic signed [COEF_WIDTH-1:0]    i_coef_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       o_out_left,
    output logic signed [SAMPLE_WIDTH-1:0]       o_out_right
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COEF_WIDTH;
    localparam int AW    = $clog2(NUM_TAPS);
    localparam int PW    = SW + 1 + CW;
    localparam int ACC_RAW = SW + CW + 3 + $clog2(NUM_TAPS);
    localparam int ACC_W = (ACC_RAW > 64) ? 64 : ACC_RAW;
    localparam int HL    = NUM_TAPS - 1;

    localparam logic signed [SW+1:0] B_HI = {2'b00, {SW{1'b1}}};
    localparam logic signed [SW+1:0] B_LO = {2'b11, {SW{1'b0}}};
    localparam logic signed [ACC_W-1:0] RND = {{(ACC_W-1){1'b0}}, 1'b1} << (CW - 3);
    localparam logic signed [ACC_W-1:0] E_HI = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] E_LO = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

    // weight store
    logic signed [CW-1:0] r_wmem [NUM_TAPS];
    logic [NUM_TAPS-1:0]  r_wvalid;
    logic signed [CW-1:0] r_rd_data;
    logic signed [CW-1:0] r_rd_init;
    logic                 r_rd_valid;

    // sample state
    logic                 r_enable;
    logic signed [SW-1:0] r_prev_right;
    logic signed [SW-1:0] r_left;
    logic signed [SW-1:0] r_right;
    logic signed [SW:0]   r_b;
    logic signed [SW:0]   r_hist [HL];

    // mac pipeline
    logic signed [SW:0]      r_opnd;
    logic                    r_s1_vld, r_s1_first;
    logic signed [PW-1:0]    r_prod;
    logic                    r_s2_vld, r_s2_first;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [SW-1:0]    r_out_left, r_out_right;
    logic                    r_out_valid;

    logic signed [SW+1:0]    bsum;
    logic signed [SW:0]      bsat;
    logic signed [CW-1:0]    wsel;
    logic signed [SW+1:0]    lr;
    logic signed [ACC_W-1:0] err;
    logic signed [ACC_W-1:0] esh;
    logic signed [SW-1:0]    esat;
    logic                    coef_in_range;

    // blocking path: left + right - previous right, saturated
    always_comb begin
        bsum = (SW+2)'(i_left_sample) + (SW+2)'(i_right_sample) - (SW+2)'(r_prev_right);
        if (bsum > B_HI) begin
            bsat = B_HI[SW:0];
        end else if (bsum < B_LO) begin
            bsat = B_LO[SW:0];
        end else begin
            bsat = bsum[SW:0];
        end
    end

    assign coef_in_range = 32'(i_coef_index) < 32'(NUM_TAPS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_coef && coef_in_range) begin
            r_wmem[AW'(i_coef_index)] <= i_coef_value;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_wmem[i_rd_addr];
            r_rd_init <= CW'(init_weight(int'(i_rd_addr), CW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid   <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_coef && coef_in_range) begin
                r_wvalid[AW'(i_coef_index)] <= 1'b1;
            end
            if (i_cmd.issue) begin
                r_rd_valid <= r_wvalid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            r_enable <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left  <= i_left_sample;
            r_right <= i_right_sample;
            r_b     <= bsat;
        end
        if (i_cmd.issue) begin
            r_opnd <= i_cmd.first ? r_b : r_hist[0];
        end
    end

    // history is rotated once per tap read after tap zero, ending where it started
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_right <= '0;
            for (int i = 0; i < HL; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_cmd.finish) begin
            r_prev_right <= r_right;
            r_hist[0]    <= r_b;
            for (int i = 1; i < HL; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end else if (i_cmd.issue && !i_cmd.first) begin
            for (int i = 0; i < HL - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[HL-1] <= r_hist[0];
        end
    end

    assign wsel = r_rd_valid ? r_rd_data : r_rd_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s1_first <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s2_first <= 1'b0;
        end else begin
            r_s1_vld   <= i_cmd.issue;
            r_s1_first <= i_cmd.first;
            r_s2_vld   <= r_s1_vld;
            r_s2_first <= r_s1_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_prod <= wsel * r_opnd;
        end
        if (r_s2_vld) begin
            r_acc <= r_s2_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    // error: reference minus filter output, rounded half up and saturated
    always_comb begin
        lr  = ((SW+2)'(r_left) <<< 1) + (SW+2)'(r_right);
        err = (ACC_W'(lr) <<< (CW - 3)) - r_acc + RND;
        esh = err >>> (CW - 2);
        if (esh > E_HI) begin
            esat = E_HI[SW-1:0];
        end else if (esh < E_LO) begin
            esat = E_LO[SW-1:0];
        end else begin
            esat = esh[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_left  <= r_enable ? esat : r_left;
            r_out_right <= r_enable ? esat : r_right;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_left      = r_out_left;
    assign o_out_right     = r_out_right;

endmodule
`default_nettype wire

>>> hdl/sidelobe_canceller_fixed_weights_unit.sv
`default_nettype none
// two-microphone sidelobe canceller with a loadable weight store
// input stream: tuser is the item kind; a sample item carries a left/right pair,
//   a coefficient item writes one weight of the blocking-path fir (index past the
//   last tap is ignored) and produces no output
// output stream: one item per sample item, the canceller error on both channels,
//   or the input pair unchanged when the enable register is 0
// config channel: one-bit enable, always ready, write only while idle
// a sample item reaches the output register by one multiply-accumulate per tap over
//   a single multiplier fed by the weight memory, the drain states S_DRAIN_A and
//   S_DRAIN_B, and rounding and saturation registered in S_DONE once that register is free
// a coefficient item is taken in the idle state, which it does not leave; a new item is
//   accepted once the previous sample item has moved into the output register
// reset restores enable to 1, clears the sample histories and returns every
//   weight to its startup value
// when the receiver stalls the result waits in the output register and the next
//   sample item is accepted and computed, but not written out until it is taken
module sidelobe_canceller_fixed_weights_unit
    import scfw_pkg::*;
#(
    parameter int NUM_TAPS     = NUM_TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_data,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // left_sample, right_sample, coef_index, coef_value, zero pad
    input  wire logic [((2*SAMPLE_WIDTH+COEF_INDEX_W+COEF_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // operation
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // out_left, out_right, zero pad
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COEF_WIDTH;
    localparam int AW    = $clog2(NUM_TAPS);
    localparam int IN_W  = 2*SW + COEF_INDEX_W + CW;
    localparam int OUT_TW = ((2*SW + 7) / 8) * 8;

    t_cmd            cmd;
    t_stat           stat;
    logic [AW-1:0]   rd_addr;
    logic signed [SW-1:0] out_left, out_right;

    scfw_ctrl #(
        .NUM_TAPS (NUM_TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    scfw_dp #(
        .NUM_TAPS     (NUM_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rd_addr      (rd_addr),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_left_sample  (i_s_axis_tdata[SW-1:0]),
        .i_right_sample (i_s_axis_tdata[2*SW-1:SW]),
        .i_coef_index   (i_s_axis_tdata[2*SW+COEF_INDEX_W-1:2*SW]),
        .i_coef_value   (i_s_axis_tdata[IN_W-1:2*SW+COEF_INDEX_W]),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_out_left     (out_left),
        .o_out_right    (out_right)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = OUT_TW'({out_right, out_left});

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import scfw_pkg::*;

    localparam int SW        = SAMPLE_WIDTH_DEF;
    localparam int CW        = COEF_WIDTH_DEF;
    localparam int TAPS      = NUM_TAPS_DEF;
    localparam int IN_W      = ((2*SW + COEF_INDEX_W + CW + 7) / 8) * 8;
    localparam int OUT_W     = ((2*SW + 7) / 8) * 8;
    localparam int LATENCY   = TAPS + 4;
    localparam int SETTLE    = LATENCY + 8;
    localparam int WDOG_MAX  = 3000;
    localparam int CHUNK     = 50;
    localparam int MAX_LINES = 40;

    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [CW-1:0] W_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] W_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic                    op;
        logic [SW-1:0]           left;
        logic [SW-1:0]           right;
        logic [COEF_INDEX_W-1:0] idx;
        logic [CW-1:0]           coef;
    } item_t;

    typedef struct packed {
        logic [SW-1:0] l;
        logic [SW-1:0] r;
    } out_pair_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_data = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tready = 1'b0;
    wire              o_cfg_ready;
    wire              o_s_axis_tready;
    wire              o_m_axis_tvalid;
    wire [OUT_W-1:0]  o_m_axis_tdata;

    sidelobe_canceller_fixed_weights_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // canceller state as seen by the predictor
    logic   enable_reg;
    longint prev_right;
    longint blocked_hist [TAPS-1];
    longint weights [TAPS];

    item_t     pending_items [$];
    out_pair_t expected_pairs [$];

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    logic in_taken = 1'b0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  pairs_done = 0;
    int  bypass_done = 0;
    int  coef_writes = 0;
    int  results_checked = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_LINES) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    task automatic predict_canceller(input item_t it);
        longint    lft;
        longint    rgt;
        longint    blk;
        longint    acc;
        longint    err;
        out_pair_t res;
        if (it.op == OP_COEF) begin
            weights[it.idx] = longint'($signed(it.coef));
            coef_writes++;
        end else begin
            lft = longint'($signed(it.left));
            rgt = longint'($signed(it.right));
            blk = clamp(lft + rgt - prev_right, SW + 1);
            acc = weights[0] * blk;
            for (int k = 1; k < TAPS; k++) begin
                acc += weights[k] * blocked_hist[k-1];
            end
            // reference moved to the accumulator scale, round half up, back to Q1.23
            err = ((2 * lft + rgt) <<< (CW - 3)) - acc + (64'sd1 <<< (CW - 3));
            err = clamp(err >>> (CW - 2), SW);
            for (int k = TAPS - 2; k > 0; k--) begin
                blocked_hist[k] = blocked_hist[k-1];
            end
            blocked_hist[0] = blk;
            prev_right = rgt;
            if (enable_reg) begin
                res.l = err[SW-1:0];
                res.r = err[SW-1:0];
            end else begin
                res.l = it.left;
                res.r = it.right;
                bypass_done++;
            end
            expected_pairs.push_back(res);
            pairs_done++;
        end
    endtask

    function automatic logic [SW-1:0] random_sample();
        logic [SW-1:0] v;
        case ($urandom_range(9))
            0: v = S_MAX;
            1: v = S_MIN;
            2, 3, 4: v = SW'($urandom());
            default: v = SW'($signed($urandom_range(8191)) - 4096);
        endcase
        return v;
    endfunction

    function automatic logic [CW-1:0] random_weight(input int idx);
        logic [CW-1:0] v;
        case ($urandom_range(9))
            6, 7: v = INIT_W_Q22[idx];
            8: v = CW'($urandom());
            9: v = $urandom_range(1) ? W_MAX : W_MIN;
            default: v = CW'($signed($urandom_range(131071)) - 65536);
        endcase
        return v;
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.op    = ($urandom_range(9) == 0) ? OP_COEF : OP_SAMPLE;
        it.left  = random_sample();
        it.right = random_sample();
        it.idx   = COEF_INDEX_W'($urandom_range(TAPS - 1));
        it.coef  = random_weight(it.idx);
        return it;
    endfunction

    task automatic queue_pair(input logic [SW-1:0] l, input logic [SW-1:0] r);
        item_t it;
        it = '{op: OP_SAMPLE, left: l, right: r, idx: '0, coef: '0};
        pending_items.push_back(it);
    endtask

    task automatic queue_weight(input int idx, input logic [CW-1:0] w);
        item_t it;
        it = '{op: OP_COEF, left: '0, right: '0, idx: idx[COEF_INDEX_W-1:0], coef: w};
        pending_items.push_back(it);
    endtask

    task automatic wait_quiet();
        while (pending_items.size() != 0 || expected_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        // a trailing weight write has no result to wait on
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        enable_reg = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // sender: hold an item until taken, otherwise offer the next one or idle
    always @(negedge i_clk) begin
        if (s_tvalid && !in_taken) begin
            s_tvalid <= 1'b1;
        end else if (i_rst_n && pending_items.size() != 0
                     && $urandom_range(99) >= src_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tuser  <= pending_items[0].op;
            s_tdata  <= IN_W'({pending_items[0].coef, pending_items[0].idx,
                               pending_items[0].right, pending_items[0].left});
        end else begin
            s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        logic      in_acc;
        logic      out_acc;
        out_pair_t exp_pair;
        in_acc  = s_tvalid && o_s_axis_tready;
        out_acc = o_m_axis_tvalid && m_tready;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_acc;
            // check before predicting so a stray result cannot match a fresh item
            if (out_acc) begin
                if (expected_pairs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", o_m_axis_tdata));
                end else begin
                    exp_pair = expected_pairs.pop_front();
                    results_checked++;
                    if (o_m_axis_tdata[SW-1:0] !== exp_pair.l) begin
                        report_mismatch($sformatf("out_left %h, expected %h",
                                                  o_m_axis_tdata[SW-1:0], exp_pair.l));
                    end
                    if (o_m_axis_tdata[2*SW-1:SW] !== exp_pair.r) begin
                        report_mismatch($sformatf("out_right %h, expected %h",
                                                  o_m_axis_tdata[2*SW-1:SW], exp_pair.r));
                    end
                end
            end
            if (in_acc) begin
                predict_canceller(pending_items.pop_front());
            end
            if (in_acc || out_acc || (cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WDOG_MAX) begin
                $display("timeout: no item moved for %0d cycles", WDOG_MAX);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int ph_enable [5];
        int ph_src [5];
        int ph_snk [5];
        int ph_count [5];
        int left_in_phase;
        ph_enable = '{1, 0, 1, 0, 1};
        ph_src    = '{25, 71, 71, 0, 0};
        ph_snk    = '{71, 25, 25, 0, 0};
        ph_count  = '{200, 150, 200, 100, 200};

        enable_reg = 1'b1;
        prev_right = 0;
        for (int k = 0; k < TAPS - 1; k++) begin
            blocked_hist[k] = 0;
        end
        for (int k = 0; k < TAPS; k++) begin
            weights[k] = (k < TABLE_LEN) ? longint'(INIT_W_Q22[k]) : 0;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            wait_quiet();
            write_enable(ph_enable[ph][0]);
            src_idle_pct = ph_src[ph];
            snk_idle_pct = ph_snk[ph];
            if (ph == 0) begin
                queue_pair('0, '0);
                queue_pair(S_MAX, S_MAX);
                // blocked path overflows low, then high
                queue_pair(S_MIN, S_MIN);
                queue_pair(S_MAX, S_MAX);
                queue_pair(S_MIN, S_MAX);
                queue_pair(SW'(1), '0);
                queue_pair({SW{1'b1}}, '0);
                queue_pair('0, SW'(1));
                queue_pair('0, {SW{1'b1}});
                // extreme weights drive the error into saturation
                queue_weight(0, W_MAX);
                queue_weight(TAPS - 1, W_MIN);
                queue_pair(S_MAX, S_MIN);
                queue_pair(S_MIN, S_MAX);
                queue_pair(S_MAX, S_MAX);
                queue_pair(S_MIN, S_MIN);
                queue_weight(0, INIT_W_Q22[0]);
                queue_weight(TAPS - 1, INIT_W_Q22[TAPS-1]);
                queue_weight(16, '0);
                queue_pair(SW'(4096), SW'(-4096));
                queue_pair(S_MIN, S_MIN);
                queue_pair(SW'(3), SW'(-5));
            end
            left_in_phase = ph_count[ph];
            while (left_in_phase > 0) begin
                for (int n = 0; n < CHUNK && left_in_phase > 0; n++) begin
                    pending_items.push_back(random_item());
                    left_in_phase--;
                end
                // the next chunk is queued only once the block has delivered everything
                wait_quiet();
            end
        end

        wait_quiet();
        $display("checked %0d results from %0d sample pairs (%0d passed through)",
                 results_checked, pairs_done, bypass_done);
        $display("%0d weight writes, enable toggled across 5 phases of varied stalls",
                 coef_writes);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
